// ----- rtl/cliu_pkg.sv -----
// Shared types, opcode codes and flag helpers for the CPU8 logic instruction unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cliu_pkg;

   localparam logic [7:0] OP_CPI = 8'hFE;
   localparam logic [7:0] OP_RRC = 8'h0F;
   localparam logic [7:0] OP_ANI = 8'hE6;
   localparam logic [7:0] OP_ANA_LO = 8'hA0;
   localparam logic [7:0] OP_ANA_HI = 8'hA7;
   localparam logic [7:0] OP_XRA_LO = 8'hA8;
   localparam logic [7:0] OP_XRA_HI = 8'hAF;

   localparam logic [2:0] SRC_B = 3'd0;
   localparam logic [2:0] SRC_C = 3'd1;
   localparam logic [2:0] SRC_D = 3'd2;
   localparam logic [2:0] SRC_E = 3'd3;
   localparam logic [2:0] SRC_H = 3'd4;
   localparam logic [2:0] SRC_L = 3'd5;
   localparam logic [2:0] SRC_M = 3'd6;

   localparam logic [31:0] CYC_SHORT = 32'd4;
   localparam logic [31:0] CYC_LONG = 32'd7;
   localparam logic [15:0] LEN_ONE = 16'd1;
   localparam logic [15:0] LEN_TWO = 16'd2;

   typedef struct packed {
      logic ac;
      logic cy;
      logic p;
      logic s;
      logic z;
   } flags_type;

   typedef struct packed {
      logic [7:0] acc;
      flags_type flags;
      logic [15:0] pc;
      logic [31:0] cycles;
   } arch_state_type;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] immediate;
      logic [7:0] reg_b;
      logic [7:0] reg_c;
      logic [7:0] reg_d;
      logic [7:0] reg_e;
      logic [7:0] reg_h;
      logic [7:0] reg_l;
      logic [7:0] mem_operand;
   } request_type;

   typedef struct packed {
      arch_state_type state;
      logic unsupported;
   } result_type;

   function automatic flags_type set_zsp(flags_type f, logic [7:0] v);
      flags_type r;
      r = f;
      r.z = (v == 8'h00);
      r.s = v[7];
      r.p = ~^v;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/cliu_exec.sv -----
// Combinational execute logic: next accumulator, flags, PC and cycle count.
// Depends on cliu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cliu_exec (
   input  wire cliu_pkg::request_type    req,
   input  wire cliu_pkg::arch_state_type cur,
   output cliu_pkg::arch_state_type      nxt,
   output logic                          unsupported
);
   import cliu_pkg::*;

   logic [7:0] operand;
   logic [7:0] diff;
   logic [2:0] sel;

   assign sel = req.opcode[2:0];
   assign diff = cur.acc - req.immediate;

   always_comb begin
      case (sel)
         SRC_B: operand = req.reg_b;
         SRC_C: operand = req.reg_c;
         SRC_D: operand = req.reg_d;
         SRC_E: operand = req.reg_e;
         SRC_H: operand = req.reg_h;
         SRC_L: operand = req.reg_l;
         SRC_M: operand = req.mem_operand;
         default: operand = cur.acc;
      endcase
   end

   always_comb begin
      nxt = cur;
      unsupported = 1'b0;
      case (req.opcode) inside
         OP_CPI: begin
            nxt.flags = set_zsp(cur.flags, diff);
            nxt.flags.cy = (cur.acc < req.immediate);
            nxt.cycles = cur.cycles + CYC_LONG;
            nxt.pc = cur.pc + LEN_TWO;
         end
         OP_RRC: begin
            nxt.acc = {cur.acc[0], cur.acc[7:1]};
            nxt.flags.cy = cur.acc[0];
            nxt.cycles = cur.cycles + CYC_SHORT;
            nxt.pc = cur.pc + LEN_ONE;
         end
         OP_ANI: begin
            nxt.acc = cur.acc & req.immediate;
            nxt.flags = set_zsp(cur.flags, cur.acc & req.immediate);
            nxt.flags.cy = 1'b0;
            nxt.flags.ac = 1'b0;
            nxt.cycles = cur.cycles + CYC_LONG;
            nxt.pc = cur.pc + LEN_TWO;
         end
         [OP_ANA_LO:OP_ANA_HI]: begin
            nxt.acc = cur.acc & operand;
            nxt.flags = set_zsp(cur.flags, cur.acc & operand);
            nxt.flags.cy = 1'b0;
            nxt.cycles = cur.cycles + ((sel == SRC_M) ? CYC_LONG : CYC_SHORT);
            nxt.pc = cur.pc + LEN_ONE;
         end
         [OP_XRA_LO:OP_XRA_HI]: begin
            nxt.acc = cur.acc ^ operand;
            nxt.flags = set_zsp(cur.flags, cur.acc ^ operand);
            nxt.flags.cy = 1'b0;
            nxt.flags.ac = 1'b0;
            nxt.cycles = cur.cycles + ((sel == SRC_M) ? CYC_LONG : CYC_SHORT);
            nxt.pc = cur.pc + LEN_ONE;
         end
         default: begin
            unsupported = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/cpu8_logic_instruction_unit.sv -----
// Top level: request register, execute stage, architectural state and result register.
// Depends on cliu_pkg and cliu_exec.
`timescale 1ns / 1ps
`default_nettype none

// One instruction is accepted every cycle unless rsp_stall holds a result in the result
// register; each passes through the request register, then the result register. The
// rate of one instruction per cycle is set by the accumulator and flag feedback loop, which
// closes through the combinational execute logic. The result shows the accumulator, flags, PC and
// cycle count after the instruction; an unknown opcode leaves all of them unchanged and
// sets rsp_unsupported. Architectural state and valid flags clear on reset; data registers do not.
module cpu8_logic_instruction_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_opcode,
   input  wire  [7:0]  req_immediate,
   input  wire  [7:0]  req_reg_b,
   input  wire  [7:0]  req_reg_c,
   input  wire  [7:0]  req_reg_d,
   input  wire  [7:0]  req_reg_e,
   input  wire  [7:0]  req_reg_h,
   input  wire  [7:0]  req_reg_l,
   input  wire  [7:0]  req_mem_operand,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_accumulator,
   output logic        rsp_zero_flag,
   output logic        rsp_sign_flag,
   output logic        rsp_parity_flag,
   output logic        rsp_carry_flag,
   output logic        rsp_aux_carry_flag,
   output logic [15:0] rsp_program_counter,
   output logic [31:0] rsp_cycle_total,
   output logic        rsp_unsupported
);
   import cliu_pkg::*;

   logic           in_valid_ff, in_valid_in;
   request_type    in_ff, in_in;
   logic           out_valid_ff, out_valid_in;
   result_type     result_ff, result_in;
   arch_state_type state_ff, state_in;
   arch_state_type exec_state;
   logic           exec_unsup;
   logic           advance;
   logic           req_take;

   assign advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   cliu_exec u_exec (
      .req         (in_ff),
      .cur         (state_ff),
      .nxt         (exec_state),
      .unsupported (exec_unsup)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in = in_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_in = '{opcode: req_opcode, immediate: req_immediate, reg_b: req_reg_b,
                   reg_c: req_reg_c, reg_d: req_reg_d, reg_e: req_reg_e,
                   reg_h: req_reg_h, reg_l: req_reg_l, mem_operand: req_mem_operand};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      result_in = result_ff;
      state_in = state_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         result_in.state = exec_state;
         result_in.unsupported = exec_unsup;
         state_in = exec_state;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff <= state_in;
      end
      in_ff <= in_in;
      result_ff <= result_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_accumulator = result_ff.state.acc;
   assign rsp_zero_flag = result_ff.state.flags.z;
   assign rsp_sign_flag = result_ff.state.flags.s;
   assign rsp_parity_flag = result_ff.state.flags.p;
   assign rsp_carry_flag = result_ff.state.flags.cy;
   assign rsp_aux_carry_flag = result_ff.state.flags.ac;
   assign rsp_program_counter = result_ff.state.pc;
   assign rsp_cycle_total = result_ff.state.cycles;
   assign rsp_unsupported = result_ff.unsupported;

   // a pending result always reflects the current architectural state
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (result_ff.state == state_ff))
      else $error("pending result differs from architectural state");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_unsup_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (advance && exec_unsup) |=> (state_ff == $past(state_ff)))
      else $error("unsupported opcode changed state");

endmodule

`default_nettype wire

// ----- test/cliu_checker.sv -----
// Checker for cpu8_logic_instruction_unit: watches both channels, predicts each result
// and compares it field by field. Depends on cliu_pkg.
`timescale 1ns / 1ps

module cliu_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_stall,
   input  wire  [7:0]  req_opcode,
   input  wire  [7:0]  req_immediate,
   input  wire  [7:0]  req_reg_b,
   input  wire  [7:0]  req_reg_c,
   input  wire  [7:0]  req_reg_d,
   input  wire  [7:0]  req_reg_e,
   input  wire  [7:0]  req_reg_h,
   input  wire  [7:0]  req_reg_l,
   input  wire  [7:0]  req_mem_operand,
   input  wire         rsp_valid,
   input  wire         rsp_stall,
   input  wire  [7:0]  rsp_accumulator,
   input  wire         rsp_zero_flag,
   input  wire         rsp_sign_flag,
   input  wire         rsp_parity_flag,
   input  wire         rsp_carry_flag,
   input  wire         rsp_aux_carry_flag,
   input  wire  [15:0] rsp_program_counter,
   input  wire  [31:0] rsp_cycle_total,
   input  wire         rsp_unsupported,
   output int          failures,
   output int          pending
);
   import cliu_pkg::*;

   arch_state_type cpu_state;
   result_type     expected_results[$];
   int             fail_count;

   function automatic flags_type result_flags(flags_type f, logic [7:0] v);
      flags_type n;
      n = f;
      n.z = (v == 8'h00);
      n.s = v[7];
      n.p = ~^v;
      return n;
   endfunction

   function automatic result_type execute_instruction(request_type r);
      result_type res;
      logic [7:0] operand;
      logic [7:0] diff;
      logic [2:0] sel;
      res.unsupported = 1'b0;
      sel = r.opcode[2:0];
      if (r.opcode == OP_CPI) begin
         diff = cpu_state.acc - r.immediate;
         cpu_state.flags = result_flags(cpu_state.flags, diff);
         cpu_state.flags.cy = (cpu_state.acc < r.immediate);
         cpu_state.cycles = cpu_state.cycles + CYC_LONG;
         cpu_state.pc = cpu_state.pc + LEN_TWO;
      end else if (r.opcode == OP_RRC) begin
         cpu_state.flags.cy = cpu_state.acc[0];
         cpu_state.acc = {cpu_state.acc[0], cpu_state.acc[7:1]};
         cpu_state.cycles = cpu_state.cycles + CYC_SHORT;
         cpu_state.pc = cpu_state.pc + LEN_ONE;
      end else if (r.opcode == OP_ANI) begin
         cpu_state.acc = cpu_state.acc & r.immediate;
         cpu_state.flags = result_flags(cpu_state.flags, cpu_state.acc);
         cpu_state.flags.cy = 1'b0;
         cpu_state.flags.ac = 1'b0;
         cpu_state.cycles = cpu_state.cycles + CYC_LONG;
         cpu_state.pc = cpu_state.pc + LEN_TWO;
      end else if (r.opcode >= OP_ANA_LO && r.opcode <= OP_XRA_HI) begin
         case (sel)
            SRC_B: operand = r.reg_b;
            SRC_C: operand = r.reg_c;
            SRC_D: operand = r.reg_d;
            SRC_E: operand = r.reg_e;
            SRC_H: operand = r.reg_h;
            SRC_L: operand = r.reg_l;
            SRC_M: operand = r.mem_operand;
            default: operand = cpu_state.acc;
         endcase
         if (r.opcode <= OP_ANA_HI) begin
            cpu_state.acc = cpu_state.acc & operand;
         end else begin
            cpu_state.acc = cpu_state.acc ^ operand;
            cpu_state.flags.ac = 1'b0;
         end
         cpu_state.flags = result_flags(cpu_state.flags, cpu_state.acc);
         cpu_state.flags.cy = 1'b0;
         cpu_state.cycles = cpu_state.cycles + ((sel == SRC_M) ? CYC_LONG : CYC_SHORT);
         cpu_state.pc = cpu_state.pc + LEN_ONE;
      end else begin
         res.unsupported = 1'b1;
      end
      res.state = cpu_state;
      return res;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      request_type req;
      result_type  exp_res;
      if (reset) begin
         cpu_state = '0;
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            req = '{req_opcode, req_immediate, req_reg_b, req_reg_c, req_reg_d,
                    req_reg_e, req_reg_h, req_reg_l, req_mem_operand};
            expected_results.push_back(execute_instruction(req));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response: acc %0h pc %0h", rsp_accumulator,
                      rsp_program_counter);
               fail_count++;
            end else begin
               exp_res = expected_results.pop_front();
               check_field("rsp_accumulator", exp_res.state.acc, rsp_accumulator);
               check_field("rsp_zero_flag", exp_res.state.flags.z, rsp_zero_flag);
               check_field("rsp_sign_flag", exp_res.state.flags.s, rsp_sign_flag);
               check_field("rsp_parity_flag", exp_res.state.flags.p, rsp_parity_flag);
               check_field("rsp_carry_flag", exp_res.state.flags.cy, rsp_carry_flag);
               check_field("rsp_aux_carry_flag", exp_res.state.flags.ac,
                           rsp_aux_carry_flag);
               check_field("rsp_program_counter", exp_res.state.pc, rsp_program_counter);
               check_field("rsp_cycle_total", exp_res.state.cycles, rsp_cycle_total);
               check_field("rsp_unsupported", exp_res.unsupported, rsp_unsupported);
            end
         end
      end
      failures <= fail_count;
      pending <= expected_results.size();
   end

endmodule

// ----- test/tb.sv -----
// Top of the testbench for cpu8_logic_instruction_unit: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on cliu_pkg, cpu8_logic_instruction_unit and cliu_checker.
`timescale 1ns / 1ps

module tb;
   import cliu_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_ITEMS = 615;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_opcode = '0;
   logic [7:0]  req_immediate = '0;
   logic [7:0]  req_reg_b = '0;
   logic [7:0]  req_reg_c = '0;
   logic [7:0]  req_reg_d = '0;
   logic [7:0]  req_reg_e = '0;
   logic [7:0]  req_reg_h = '0;
   logic [7:0]  req_reg_l = '0;
   logic [7:0]  req_mem_operand = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_accumulator;
   logic        rsp_zero_flag;
   logic        rsp_sign_flag;
   logic        rsp_parity_flag;
   logic        rsp_carry_flag;
   logic        rsp_aux_carry_flag;
   logic [15:0] rsp_program_counter;
   logic [31:0] rsp_cycle_total;
   logic        rsp_unsupported;

   int failures;
   int pending;
   int send_idle_pct = 0;
   int stall_pct = 0;

   cpu8_logic_instruction_unit DUT (.*);

   cliu_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   function automatic logic [7:0] random_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] random_opcode();
      int k;
      k = $urandom_range(99);
      if (k < 15) return 8'($urandom);
      else if (k < 27) return OP_CPI;
      else if (k < 37) return OP_RRC;
      else if (k < 49) return OP_ANI;
      else return 8'(OP_ANA_LO + $urandom_range(15));
   endfunction

   function automatic request_type random_request();
      request_type r;
      r.opcode = random_opcode();
      r.immediate = random_byte();
      r.reg_b = random_byte();
      r.reg_c = random_byte();
      r.reg_d = random_byte();
      r.reg_e = random_byte();
      r.reg_h = random_byte();
      r.reg_l = random_byte();
      r.mem_operand = random_byte();
      return r;
   endfunction

   // val goes to the source an ANA/XRA opcode reads (not A), else to the immediate; all else stays random
   function automatic request_type with_operand(logic [7:0] op, logic [7:0] val);
      request_type r;
      r = random_request();
      r.opcode = op;
      if (op >= OP_ANA_LO && op <= OP_XRA_HI) begin
         case (op[2:0])
            SRC_B: r.reg_b = val;
            SRC_C: r.reg_c = val;
            SRC_D: r.reg_d = val;
            SRC_E: r.reg_e = val;
            SRC_H: r.reg_h = val;
            SRC_L: r.reg_l = val;
            SRC_M: r.mem_operand = val;
            default: ;
         endcase
      end else begin
         r.immediate = val;
      end
      return r;
   endfunction

   task automatic send_request(request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= r.opcode;
      req_immediate <= r.immediate;
      req_reg_b <= r.reg_b;
      req_reg_c <= r.reg_c;
      req_reg_d <= r.reg_d;
      req_reg_e <= r.reg_e;
      req_reg_h <= r.reg_h;
      req_reg_l <= r.reg_l;
      req_mem_operand <= r.mem_operand;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic run_random(int idle, int stall, int count);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain();
         send_request(random_request());
      end
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 23;
      stall_pct = 58;
      send_request(with_operand(OP_XRA_HI, 8'h00));
      send_request(with_operand(8'hA8, 8'hFF));
      send_request(with_operand(8'hA1, 8'h0F));
      send_request(with_operand(8'hA2, 8'hFF));
      send_request(with_operand(8'hA3, 8'hF3));
      send_request(with_operand(OP_RRC, 8'h00));
      send_request(with_operand(OP_RRC, 8'h00));
      send_request(with_operand(8'hA4, 8'hFF));
      send_request(with_operand(8'hA5, 8'h81));
      send_request(with_operand(8'hA6, 8'h01));
      send_request(with_operand(OP_ANA_HI, 8'h00));
      send_request(with_operand(8'hA9, 8'h80));
      send_request(with_operand(8'hAA, 8'h00));
      send_request(with_operand(8'hAB, 8'h55));
      send_request(with_operand(8'hAC, 8'hAA));
      send_request(with_operand(8'hAD, 8'hFF));
      send_request(with_operand(8'hAE, 8'h7F));
      send_request(with_operand(OP_CPI, 8'hFF));
      send_request(with_operand(OP_CPI, 8'h00));
      send_request(with_operand(OP_ANI, 8'hFF));
      send_request(with_operand(OP_ANI, 8'h00));
      // unknown opcodes, including the neighbors of the supported ranges
      send_request(with_operand(8'h00, 8'hFF));
      send_request(with_operand(8'hFF, 8'hFF));
      send_request(with_operand(8'h9F, 8'h00));
      send_request(with_operand(8'hB0, 8'h00));
      send_request(with_operand(8'hE7, 8'h00));
      drain();

      run_random(23, 58, PHASE_ITEMS);
      run_random(58, 23, PHASE_ITEMS);
      run_random(0, 0, PHASE_ITEMS);
      repeat (8) @(posedge clock);

      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
